// ===== src/decaying_rate_meter_macros.svh =====
// Assertion macros for the decaying rate meter.
`ifndef DECAYING_RATE_METER_MACROS_SVH
`define DECAYING_RATE_METER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define DRM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decaying_rate_meter check failed");

// Next-cycle implication, disabled during reset
`define DRM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decaying_rate_meter check failed");

`else

`define DRM_ASSERT_NOW(label, ante, cons)
`define DRM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== src/drm_pkg.sv =====
// Package for the decaying rate meter: widths, constants and sequencer states.
`timescale 1ns / 1ps

package drm_pkg;

  // Field widths
  localparam int unsigned SEC_W   = 32;
  localparam int unsigned USEC_W  = 20;
  localparam int unsigned AMT_W   = 32;
  localparam int unsigned TOTAL_W = 64;
  localparam int unsigned RATE_W  = 32;
  localparam int unsigned CNT_W   = 8;

  // Packed stream widths (input padded to whole bytes)
  localparam int unsigned S_DATA_W = 88;
  localparam int unsigned M_DATA_W = 96;

  // Time base and decay constants
  localparam logic [22:0]       USEC_PER_SEC  = 23'd1000000;
  localparam int unsigned       TICKS_PER_SEC = 7;
  localparam logic [CNT_W-1:0]  HISTORY_TICKS = 8'd166;
  localparam logic [RATE_W-1:0] SCALE_LIMIT   = 32'h0FFF_FFFF;

  // Action codes
  localparam logic ACT_COUNT = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_UPDATE,
    ST_DECAY,
    ST_DONE
  } state_t;

endpackage

// ===== src/decaying_rate_meter.sv =====
// Decaying rate meter: tick conversion, iterative rate decay and scaled read-out.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tdata: now_sec, now_usec, amount; tuser: action
//  m_*     | out | m_tvalid/m_tready  | tdata: running_total, rate_per_sec
//
// Each item passes the states tick, update, decay and done; decay does d 7/8 steps,
// where d (0..166) is the elapsed tick count, in the one shared decay unit, stopping
// early when the rate reaches zero; an item past the history window skips decay.
// s_tready is high only while the sequencer is idle; one finished result can
// wait in the output register while the next item is accepted and worked on.
// rst is synchronous and clears total, rate and last tick to zero.
`timescale 1ns / 1ps
`include "decaying_rate_meter_macros.svh"

module decaying_rate_meter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata: now_sec[31:0], now_usec[51:32], amount[83:52], zero pad[87:84]
  input  logic [drm_pkg::S_DATA_W-1:0]  s_tdata,
  // s_tuser: action[0]
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata: running_total[63:0], rate_per_sec[95:64]
  output logic [drm_pkg::M_DATA_W-1:0]  m_tdata
);

  // One decay step: floor(r*7/8) = r - ceil(r/8)
  function automatic logic [drm_pkg::RATE_W-1:0] decay_step(
    input logic [drm_pkg::RATE_W-1:0] r
  );
    logic [drm_pkg::RATE_W:0] w;
    w = {1'b0, r} + 33'd7;
    return r - {2'b00, w[drm_pkg::RATE_W:3]};
  endfunction

  // Rate per second from the internal rate
  function automatic logic [drm_pkg::RATE_W-1:0] scale_rate(
    input logic [drm_pkg::RATE_W-1:0] r
  );
    logic [drm_pkg::RATE_W-1:0] e;
    logic [drm_pkg::RATE_W-1:0] t;
    e = {3'b000, r[drm_pkg::RATE_W-1:3]};
    t = {r[drm_pkg::RATE_W-4:0], 3'b000} - r + 32'd7;
    if (r > drm_pkg::SCALE_LIMIT) begin
      return {e[drm_pkg::RATE_W-4:0], 3'b000} - e;
    end
    return {3'b000, t[drm_pkg::RATE_W-1:3]};
  endfunction

  drm_pkg::state_t state, state_next;

  // Meter state
  logic [drm_pkg::TOTAL_W-1:0] total;
  logic [drm_pkg::RATE_W-1:0]  rate;
  logic [drm_pkg::SEC_W-1:0]   last_tick;

  // Item working registers
  logic [drm_pkg::SEC_W-1:0]   sec;
  logic [drm_pkg::USEC_W-1:0]  usec;
  logic [drm_pkg::AMT_W-1:0]   amt;
  logic [drm_pkg::SEC_W-1:0]   tick;
  logic [drm_pkg::CNT_W-1:0]   count;

  logic                        s_accept;
  logic                        out_free;
  logic [22:0]                 usec7;
  logic [2:0]                  frac;
  logic [drm_pkg::SEC_W-1:0]   tick_calc;
  logic [drm_pkg::SEC_W-1:0]   elapsed;
  logic                        ld_out;

  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Tick = sec*7 + floor(usec*7/1e6); the fraction is a count of threshold hits
  always_comb begin
    usec7 = {usec, 3'b000} - {3'b000, usec};
    frac  = 3'd0;
    for (int k = 1; k <= drm_pkg::TICKS_PER_SEC; k++) begin
      if (usec7 >= 23'(k) * drm_pkg::USEC_PER_SEC) begin
        frac = frac + 3'd1;
      end
    end
    tick_calc = {sec[drm_pkg::SEC_W-4:0], 3'b000} - sec + {29'd0, frac};
  end

  assign elapsed = tick - last_tick;

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= drm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and controls
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ld_out     = 1'b0;
    case (state)
      drm_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = drm_pkg::ST_TICK;
        end
      end
      drm_pkg::ST_TICK: begin
        state_next = drm_pkg::ST_UPDATE;
      end
      drm_pkg::ST_UPDATE: begin
        if (elapsed > {24'd0, drm_pkg::HISTORY_TICKS}) begin
          state_next = drm_pkg::ST_DONE;
        end else begin
          state_next = drm_pkg::ST_DECAY;
        end
      end
      drm_pkg::ST_DECAY: begin
        if (count == '0 || rate == '0) begin
          state_next = drm_pkg::ST_DONE;
        end
      end
      drm_pkg::ST_DONE: begin
        if (out_free) begin
          ld_out     = 1'b1;
          state_next = drm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = drm_pkg::ST_IDLE;
      end
    endcase
  end

  // Meter state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      rate      <= '0;
      last_tick <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (state == drm_pkg::ST_UPDATE) begin
        total     <= total + {32'd0, amt};
        last_tick <= tick;
        if (elapsed > {24'd0, drm_pkg::HISTORY_TICKS}) begin
          rate <= amt;
        end
      end
      // shared decay unit, one step per cycle; amount folded in at the end
      if (state == drm_pkg::ST_DECAY) begin
        if (count == '0 || rate == '0) begin
          rate <= rate + amt;
        end else begin
          rate <= decay_step(rate);
        end
      end
      if (ld_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Item capture, tick, step count and result payload
  always_ff @(posedge clk) begin
    if (s_accept) begin
      sec  <= s_tdata[31:0];
      usec <= s_tdata[51:32];
      amt  <= (s_tuser == drm_pkg::ACT_READ) ? '0 : s_tdata[83:52];
    end
    if (state == drm_pkg::ST_TICK) begin
      tick <= tick_calc;
    end
    if (state == drm_pkg::ST_UPDATE) begin
      count <= elapsed[drm_pkg::CNT_W-1:0];
    end else if (state == drm_pkg::ST_DECAY && count != '0) begin
      count <= count - 8'd1;
    end
    if (ld_out) begin
      m_tdata <= {scale_rate(rate), total};
    end
  end

  // Checks
  `DRM_ASSERT_NEXT(a_busy_after_accept, s_accept, !s_tready)
  `DRM_ASSERT_NOW(a_count_in_history, state == drm_pkg::ST_DECAY, count <= drm_pkg::HISTORY_TICKS)
  `DRM_ASSERT_NOW(a_result_from_done, $rose(m_tvalid), $past(state == drm_pkg::ST_DONE))

endmodule

// ===== dv/decaying_rate_meter_check.sv =====
// Checker for the decaying rate meter: predicts each reading and compares it with the output.
`timescale 1ns / 1ps

module decaying_rate_meter_check (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  // s_tdata: now_sec[31:0], now_usec[51:32], amount[83:52], zero pad[87:84]
  input  logic [drm_pkg::S_DATA_W-1:0] s_tdata,
  // s_tuser: action[0]
  input  logic                         s_tuser,
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  // m_tdata: running_total[63:0], rate_per_sec[95:64]
  input  logic [drm_pkg::M_DATA_W-1:0] m_tdata,
  output int unsigned                  errors,
  output int unsigned                  pending,
  output int unsigned                  readings_checked,
  output int unsigned                  reads_seen,
  output int unsigned                  expired_seen
);
  import drm_pkg::*;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [RATE_W-1:0]  rate;
  } meter_reading_t;

  // Readings still owed by the block, oldest first
  meter_reading_t readings_q[$];

  // Own copy of the meter state
  logic [TOTAL_W-1:0] total_mdl;
  logic [RATE_W-1:0]  rate_mdl;
  logic [31:0]        last_tick_mdl;

  int unsigned err_cnt, chk_cnt, read_cnt, expired_cnt;

  // One 7/8 step, truncating, computed without wrap
  function automatic logic [RATE_W-1:0] decay_step(input logic [RATE_W-1:0] r);
    logic [63:0] w;
    w = {32'b0, r};
    return RATE_W'(w - (w + 64'd7) / 64'd8);
  endfunction

  // Apply one item to the meter state and return the reading it produces
  function automatic meter_reading_t advance_meter(input logic act,
                                                   input logic [SEC_W-1:0] sec,
                                                   input logic [USEC_W-1:0] usec,
                                                   input logic [AMT_W-1:0] amt_in);
    logic [AMT_W-1:0]  amt;
    logic [31:0]       now, elapsed;
    logic [RATE_W-1:0] r;
    logic [63:0]       frac, scaled;
    meter_reading_t    rd;
    amt = (act == ACT_READ) ? '0 : amt_in;
    if (act == ACT_READ) read_cnt++;
    frac = {44'b0, usec} * 64'd7 / 64'd1000000;
    now = sec * 32'd7 + frac[31:0];
    elapsed = now - last_tick_mdl;
    total_mdl = total_mdl + {32'b0, amt};
    if (elapsed > 32'(HISTORY_TICKS)) begin
      // history has decayed away (or time went backwards)
      rate_mdl = amt;
      expired_cnt++;
    end else begin
      r = rate_mdl;
      for (int unsigned k = 0; k < elapsed && r != '0; k++) r = decay_step(r);
      rate_mdl = r + amt;
    end
    last_tick_mdl = now;
    // scale to units per second
    if (rate_mdl > SCALE_LIMIT) scaled = {32'b0, rate_mdl / 32'd8} * 64'd7;
    else scaled = ({32'b0, rate_mdl} * 64'd7 + 64'd7) / 64'd8;
    rd.total = total_mdl;
    rd.rate  = scaled[RATE_W-1:0];
    return rd;
  endfunction

  always @(posedge clk) begin : watch
    meter_reading_t want;
    logic [TOTAL_W-1:0] got_total;
    logic [RATE_W-1:0]  got_rate;
    if (rst) begin
      total_mdl     = '0;
      rate_mdl      = '0;
      last_tick_mdl = '0;
      readings_q.delete();
    end else begin
      // output side first: a reading leaving now belongs to an earlier item
      if (m_tvalid && m_tready) begin
        got_total = m_tdata[TOTAL_W-1:0];
        got_rate  = m_tdata[TOTAL_W +: RATE_W];
        if (readings_q.size() == 0) begin
          $error("reading: none expected, got total %h rate %h", got_total, got_rate);
          err_cnt++;
        end else begin
          want = readings_q.pop_front();
          chk_cnt++;
          if (got_total !== want.total) begin
            $error("running_total: expected %h, got %h", want.total, got_total);
            err_cnt++;
          end
          if (got_rate !== want.rate) begin
            $error("rate_per_sec: expected %h, got %h", want.rate, got_rate);
            err_cnt++;
          end
        end
      end
      if (s_tvalid && s_tready)
        readings_q.push_back(advance_meter(s_tuser, s_tdata[SEC_W-1:0],
                                           s_tdata[SEC_W +: USEC_W],
                                           s_tdata[SEC_W+USEC_W +: AMT_W]));
    end
    errors           <= err_cnt;
    pending          <= readings_q.size();
    readings_checked <= chk_cnt;
    reads_seen       <= read_cnt;
    expired_seen     <= expired_cnt;
  end

endmodule

// ===== dv/decaying_rate_meter_test.sv =====
// Testbench top for the decaying rate meter: stimulus, stalls and the final verdict.
`timescale 1ns / 1ps

module decaying_rate_meter_test;
  import drm_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1334;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic                s_tuser  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  // no idling on either side while set
  logic        calm = 1'b0;
  logic [31:0] cur_tick = '0;
  int unsigned items_sent = 0;

  int unsigned errors, pending, readings_checked, reads_seen, expired_seen;

  decaying_rate_meter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  decaying_rate_meter_check check (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tuser          (s_tuser),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .errors           (errors),
    .pending          (pending),
    .readings_checked (readings_checked),
    .reads_seen       (reads_seen),
    .expired_seen     (expired_seen)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver stalls at random, about 8 percent of the time
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= 8);
  end

  // Offer one item, with a random gap first, and hold it until accepted
  task automatic send_item(input logic act, input logic [SEC_W-1:0] sec,
                           input logic [USEC_W-1:0] usec, input logic [AMT_W-1:0] amt);
    while (!calm && $urandom_range(0, 99) < 8) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {4'b0, amt, usec, sec};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Hold off the sender until every reading is back
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Seconds and microseconds that land on a given tick; spread picks anywhere in the tick
  task automatic split_tick(input logic [31:0] tick, input bit spread,
                            output logic [SEC_W-1:0] sec, output logic [USEC_W-1:0] usec);
    int unsigned rem, lo, hi;
    rem = tick % 7;
    sec = tick / 7;
    lo  = (rem * 1000000 + 6) / 7;
    hi  = ((rem + 1) * 1000000 + 6) / 7 - 1;
    if (spread && rem == 0 && sec != '0 && $urandom_range(0, 3) == 0) begin
      // microseconds past a whole second roll into the next tick
      sec  = sec - 1;
      usec = USEC_W'($urandom_range(1000000, 1048575));
    end else begin
      usec = USEC_W'(spread ? $urandom_range(lo, hi) : lo);
    end
  endtask

  task automatic send_at(input logic act, input logic [31:0] tick, input logic [AMT_W-1:0] amt);
    logic [SEC_W-1:0]  sec;
    logic [USEC_W-1:0] usec;
    split_tick(tick, 1'b0, sec, usec);
    send_item(act, sec, usec, amt);
  endtask

  // Mostly steady time with small steps, some long gaps, backward jumps and wild times
  task automatic random_item();
    int unsigned       pick, apick;
    logic [SEC_W-1:0]  sec;
    logic [USEC_W-1:0] usec;
    logic [AMT_W-1:0]  amt;
    logic              act;
    pick = $urandom_range(0, 99);
    if (pick < 40)      cur_tick += $urandom_range(0, 8);
    else if (pick < 68) cur_tick += $urandom_range(9, 166);
    else if (pick < 80) cur_tick += $urandom_range(163, 170);
    else if (pick < 94) cur_tick -= (pick < 88) ? 0 : $urandom_range(1, 60);
    if (pick >= 94) begin
      sec      = $urandom;
      usec     = USEC_W'($urandom_range(0, 1048575));
      cur_tick = sec * 32'd7 + ({12'b0, usec} * 32'd7) / 32'd1000000;
    end else begin
      split_tick(cur_tick, 1'b1, sec, usec);
    end
    apick = $urandom_range(0, 99);
    if (apick < 30)      amt = $urandom_range(0, 255);
    else if (apick < 55) amt = $urandom;
    else if (apick < 68) amt = 32'hFFFF_FFFF - $urandom_range(0, 15);
    else if (apick < 78) amt = '0;
    else                 amt = $urandom_range(0, 1 << 20);
    act = ($urandom_range(0, 99) < 22) ? ACT_READ : ACT_COUNT;
    send_item(act, sec, usec, amt);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // same tick as reset, then rate overflow
    send_at(ACT_COUNT, 32'd0, 32'd0);
    send_at(ACT_COUNT, 32'd0, 32'hFFFF_FFFF);
    send_at(ACT_COUNT, 32'd0, 32'd1);
    // decay of a zero rate, then from the top of the range
    send_at(ACT_COUNT, 32'd7, 32'hFFFF_FFFF);
    send_at(ACT_READ, 32'd8, 32'h1234_5678);
    // longest decay, then just past the history window
    send_at(ACT_COUNT, 32'd174, 32'd0);
    send_at(ACT_COUNT, 32'd341, 32'hFFFF_FFFF);
    send_at(ACT_READ, 32'd507, 32'hFFFF_FFFF);
    // time going backwards; scaling either side of its limit
    send_at(ACT_COUNT, 32'd0, 32'h0FFF_FFFF);
    send_at(ACT_COUNT, 32'd0, 32'd1);
    // microseconds beyond a second
    send_item(ACT_READ, 32'd0, 20'hFFFFF, 32'd0);
    // tick wraps at the top of the seconds range, then one tick over the wrap
    send_item(ACT_COUNT, 32'hFFFF_FFFF, 20'd999999, 32'h8000_0000);
    send_item(ACT_COUNT, 32'd0, 20'd0, 32'd0);
    send_item(ACT_READ, 32'd0, 20'd0, 32'd0);
    // both edges of one tick
    send_item(ACT_COUNT, 32'd0, 20'd428572, 32'hFFFF_FFFF);
    send_item(ACT_READ, 32'd0, 20'd571428, 32'd0);
    cur_tick = 32'd3;
    wait_drain();

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      calm <= (n >= 500 && n < 800);
      if (n == 900) wait_drain();
      random_item();
    end

    wait_drain();
    repeat (200) @(posedge clk);
    $display("Sent %0d items (%0d reads), checked %0d readings, %0d history restarts.",
             items_sent, reads_seen, readings_checked, expired_seen);
    $display("Time steps covered same tick, decay depths up to the window, wraps and jumps back.");
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
